@@ rtl/core/pfc_ss_pkg.sv @@
// Package: shared types, operation codes and register indexes of the PFC start-up supervisor.
`default_nettype none
package pfc_ss_pkg;

   // Supervisor modes, encoded as reported on pfc_mode
   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_CHARGING = 2'd1,
      MODE_READY    = 2'd2,
      MODE_FAULT    = 2'd3
   } mode_type;

   localparam int OPCODE_BITS = 2;
   typedef logic [OPCODE_BITS-1:0] opcode_type;

   localparam opcode_type OP_TICK  = 2'd0;
   localparam opcode_type OP_START = 2'd1;
   localparam opcode_type OP_STOP  = 2'd2;

   // Delay registers are 16 bits wide whatever the timer width
   localparam int DELAY_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_READY_LEVEL      = 3'd0;
   localparam csr_index_type CSR_READY_HYSTERESIS = 3'd1;
   localparam csr_index_type CSR_STARTUP_DELAY    = 3'd2;
   localparam csr_index_type CSR_READY_DELAY      = 3'd3;
   localparam csr_index_type CSR_DROPOUT_TIME     = 3'd4;
   localparam csr_index_type CSR_RESTART_DELAY    = 3'd5;

   localparam int RST_READY_LEVEL      = 3000;
   localparam int RST_READY_HYSTERESIS = 100;
   localparam int RST_STARTUP_DELAY    = 100;
   localparam int RST_READY_DELAY      = 50;
   localparam int RST_DROPOUT_TIME     = 20;
   localparam int RST_RESTART_DELAY    = 1000;

endpackage
`default_nettype wire

@@ rtl/core/pfc_ss_req_if.sv @@
// Interface: request channel carrying ticks, start requests and force-offs.
`default_nettype none
interface pfc_ss_req_if #(
   parameter int CODE_BITS = 12
);
   import pfc_ss_pkg::*;

   logic                 valid;
   logic                 ready;
   opcode_type           opcode;
   logic [CODE_BITS-1:0] bus_code;
   logic                 fault_in;

   modport source (output valid, input ready, output opcode, output bus_code, output fault_in);
   modport sink   (input valid, output ready, input opcode, input bus_code, input fault_in);
endinterface
`default_nettype wire

@@ rtl/core/pfc_ss_rsp_if.sv @@
// Interface: response channel carrying the supervisor status after each transaction.
`default_nettype none
interface pfc_ss_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] pfc_mode;
   logic       converter_enable;
   logic       relay_closed;
   logic       bus_ready;

   modport source (output valid, input ready, output pfc_mode, output converter_enable,
                   output relay_closed, output bus_ready);
   modport sink   (input valid, output ready, input pfc_mode, input converter_enable,
                   input relay_closed, input bus_ready);
endinterface
`default_nettype wire

@@ rtl/core/pfc_ss_csr_if.sv @@
// Interface: configuration write channel with register index and write data.
`default_nettype none
interface pfc_ss_csr_if;
   import pfc_ss_pkg::*;

   logic                     valid;
   logic                     ready;
   csr_index_type            index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, input ready, output index, output data);
   modport sink   (input valid, output ready, input index, input data);
endinterface
`default_nettype wire

@@ rtl/core/pfc_startup_supervisor.sv @@
// Top level: PFC start-up supervisor with input register, state update and status output.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  req_bus  | in  | valid/ready   | opcode, bus_code, fault_in
//  rsp_bus  | out | valid/ready   | pfc_mode, converter_enable, relay_closed, bus_ready
//  csr_bus  | in  | valid/ready   | index, data (always ready)
//
// One transaction per cycle sustained while the response is not stalled; each request
// passes the input register, then the state/result register. The state update for one
// transaction is a single pass of compares and saturating increments.
// Synchronous reset returns the machine to idle with the register reset values.
// A stalled response holds the state register; the input register takes one more
// transaction and then stalls the request side.
`default_nettype none
module pfc_startup_supervisor #(
   parameter int TIMER_BITS = 16,
   parameter int CODE_BITS  = 12
) (
   input  wire           clock,
   input  wire           reset,
   pfc_ss_req_if.sink    req_bus,
   pfc_ss_rsp_if.source  rsp_bus,
   pfc_ss_csr_if.sink    csr_bus
);
   import pfc_ss_pkg::*;

   // Compare width covers both the timers and the 16-bit delay registers
   localparam int CMP_BITS = (TIMER_BITS > DELAY_BITS) ? TIMER_BITS : DELAY_BITS;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   // ---------------- configuration registers ----------------
   logic [CODE_BITS-1:0]  ready_level_ff;
   logic [CODE_BITS-1:0]  ready_hysteresis_ff;
   logic [DELAY_BITS-1:0] startup_delay_ff;
   logic [DELAY_BITS-1:0] ready_delay_ff;
   logic [DELAY_BITS-1:0] dropout_time_ff;
   logic [DELAY_BITS-1:0] restart_delay_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_level_ff      <= CODE_BITS'(RST_READY_LEVEL);
         ready_hysteresis_ff <= CODE_BITS'(RST_READY_HYSTERESIS);
         startup_delay_ff    <= DELAY_BITS'(RST_STARTUP_DELAY);
         ready_delay_ff      <= DELAY_BITS'(RST_READY_DELAY);
         dropout_time_ff     <= DELAY_BITS'(RST_DROPOUT_TIME);
         restart_delay_ff    <= DELAY_BITS'(RST_RESTART_DELAY);
      end else if (csr_bus.valid) begin
         // drop writes beyond the register list
         case (csr_bus.index)
            CSR_READY_LEVEL:      ready_level_ff      <= csr_bus.data[CODE_BITS-1:0];
            CSR_READY_HYSTERESIS: ready_hysteresis_ff <= csr_bus.data[CODE_BITS-1:0];
            CSR_STARTUP_DELAY:    startup_delay_ff    <= csr_bus.data[DELAY_BITS-1:0];
            CSR_READY_DELAY:      ready_delay_ff      <= csr_bus.data[DELAY_BITS-1:0];
            CSR_DROPOUT_TIME:     dropout_time_ff     <= csr_bus.data[DELAY_BITS-1:0];
            CSR_RESTART_DELAY:    restart_delay_ff    <= csr_bus.data[DELAY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                 in_valid_ff;
   opcode_type           in_opcode_ff;
   logic [CODE_BITS-1:0] in_bus_ff;
   logic                 in_fault_ff;
   logic                 out_valid_ff;
   logic                 advance;

   // move the held transaction into the state stage when the response slot frees up
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_opcode_ff <= req_bus.opcode;
         in_bus_ff    <= req_bus.bus_code;
         in_fault_ff  <= req_bus.fault_in;
      end
   end

   // ---------------- supervisor state ----------------
   mode_type              mode_ff, mode_in;
   logic                  run_cmd_ff, run_cmd_in;
   logic [TIMER_BITS-1:0] time_ff, time_in;
   logic                  good_seen_ff, good_seen_in;
   logic [TIMER_BITS-1:0] good_elapsed_ff, good_elapsed_in;
   logic                  low_seen_ff, low_seen_in;
   logic [TIMER_BITS-1:0] low_elapsed_ff, low_elapsed_in;

   logic [TIMER_BITS-1:0] time_inc;
   logic [TIMER_BITS-1:0] good_inc;
   logic [TIMER_BITS-1:0] low_inc;
   logic [CODE_BITS-1:0]  lower_level;
   logic                  do_enter;
   mode_type              enter_target;

   // saturating increments of the three timers
   assign time_inc = (time_ff == TIMER_MAX) ? time_ff : time_ff + 1'b1;
   assign good_inc = (good_elapsed_ff == TIMER_MAX) ? good_elapsed_ff : good_elapsed_ff + 1'b1;
   assign low_inc  = (low_elapsed_ff == TIMER_MAX) ? low_elapsed_ff : low_elapsed_ff + 1'b1;

   // dropout threshold, clamped at zero when the margin exceeds the level
   assign lower_level = (ready_hysteresis_ff > ready_level_ff) ?
                        '0 : ready_level_ff - ready_hysteresis_ff;

   always_comb begin
      mode_in         = mode_ff;
      run_cmd_in      = run_cmd_ff;
      time_in         = time_ff;
      good_seen_in    = good_seen_ff;
      good_elapsed_in = good_elapsed_ff;
      low_seen_in     = low_seen_ff;
      low_elapsed_in  = low_elapsed_ff;
      do_enter        = 1'b0;
      enter_target    = mode_ff;

      case (in_opcode_ff)
         OP_TICK: begin
            // advance all timers first, qualifiers only while armed
            time_in = time_inc;
            if (good_seen_ff) begin
               good_elapsed_in = good_inc;
            end
            if (low_seen_ff) begin
               low_elapsed_in = low_inc;
            end

            if (in_fault_ff && (mode_ff != MODE_FAULT)) begin
               // a fault preempts everything else on this tick
               do_enter     = 1'b1;
               enter_target = MODE_FAULT;
            end else begin
               case (mode_ff)
                  MODE_IDLE: begin
                     if (run_cmd_ff &&
                         (CMP_BITS'(time_inc) >= CMP_BITS'(startup_delay_ff))) begin
                        do_enter     = 1'b1;
                        enter_target = MODE_CHARGING;
                     end
                  end
                  MODE_CHARGING: begin
                     if (!run_cmd_ff) begin
                        do_enter     = 1'b1;
                        enter_target = MODE_IDLE;
                     end else if (in_bus_ff >= ready_level_ff) begin
                        // first good tick only arms the qualifier
                        if (!good_seen_ff) begin
                           good_seen_in    = 1'b1;
                           good_elapsed_in = '0;
                        end else if (CMP_BITS'(good_inc) >= CMP_BITS'(ready_delay_ff)) begin
                           do_enter     = 1'b1;
                           enter_target = MODE_READY;
                        end
                     end else begin
                        good_seen_in    = 1'b0;
                        good_elapsed_in = '0;
                     end
                  end
                  MODE_READY: begin
                     if (!run_cmd_ff) begin
                        do_enter     = 1'b1;
                        enter_target = MODE_IDLE;
                     end else if (in_bus_ff >= lower_level) begin
                        low_seen_in    = 1'b0;
                        low_elapsed_in = '0;
                     end else if (!low_seen_ff) begin
                        low_seen_in    = 1'b1;
                        low_elapsed_in = '0;
                     end else if (CMP_BITS'(low_inc) >= CMP_BITS'(dropout_time_ff)) begin
                        do_enter     = 1'b1;
                        enter_target = MODE_CHARGING;
                     end
                  end
                  MODE_FAULT: begin
                     if (!run_cmd_ff) begin
                        if (!in_fault_ff) begin
                           do_enter     = 1'b1;
                           enter_target = MODE_IDLE;
                        end
                     end else if (!in_fault_ff &&
                                  (CMP_BITS'(time_inc) >= CMP_BITS'(restart_delay_ff))) begin
                        do_enter     = 1'b1;
                        enter_target = MODE_CHARGING;
                     end
                  end
                  default: ;
               endcase
            end
         end
         OP_START: begin
            // in idle the start-up wait keeps counting
            run_cmd_in = 1'b1;
            if (mode_ff != MODE_IDLE) begin
               time_in = '0;
            end
         end
         OP_STOP: begin
            run_cmd_in = 1'b0;
            if (mode_ff != MODE_IDLE) begin
               do_enter     = 1'b1;
               enter_target = MODE_IDLE;
            end
         end
         default: ;
      endcase

      // entering a state restarts its timer and both qualifiers
      if (do_enter) begin
         mode_in         = enter_target;
         time_in         = '0;
         good_seen_in    = 1'b0;
         good_elapsed_in = '0;
         low_seen_in     = 1'b0;
         low_elapsed_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         run_cmd_ff      <= 1'b0;
         time_ff         <= '0;
         good_seen_ff    <= 1'b0;
         good_elapsed_ff <= '0;
         low_seen_ff     <= 1'b0;
         low_elapsed_ff  <= '0;
      end else if (advance) begin
         mode_ff         <= mode_in;
         run_cmd_ff      <= run_cmd_in;
         time_ff         <= time_in;
         good_seen_ff    <= good_seen_in;
         good_elapsed_ff <= good_elapsed_in;
         low_seen_ff     <= low_seen_in;
         low_elapsed_ff  <= low_elapsed_in;
      end
   end

   // ---------------- response ----------------
   // the state register doubles as the result register; hold it while the response stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.pfc_mode         = mode_ff;
   assign rsp_bus.converter_enable = (mode_ff == MODE_CHARGING) || (mode_ff == MODE_READY);
   assign rsp_bus.relay_closed     = (mode_ff == MODE_READY);
   assign rsp_bus.bus_ready        = (mode_ff == MODE_READY);

`ifndef SYNTHESIS
   // the good-bus qualifier only lives in charging
   a_good_in_charging: assert property (@(posedge clock) disable iff (reset)
      good_seen_ff |-> (mode_ff == MODE_CHARGING))
      else $error("good qualifier armed outside charging");

   // the dropout qualifier only lives in ready
   a_low_in_ready: assert property (@(posedge clock) disable iff (reset)
      low_seen_ff |-> (mode_ff == MODE_READY))
      else $error("dropout qualifier armed outside ready");

   // an unarmed qualifier holds no elapsed time
   a_qual_clear: assert property (@(posedge clock) disable iff (reset)
      ((!good_seen_ff) |-> (good_elapsed_ff == '0)) and
      ((!low_seen_ff) |-> (low_elapsed_ff == '0)))
      else $error("qualifier counter running while unarmed");

   // the converter only runs under a standing command
   a_enable_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      ((mode_ff == MODE_CHARGING) || (mode_ff == MODE_READY)) |-> run_cmd_ff)
      else $error("converter enabled without run command");

   // a stalled response must freeze the state stage
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> $stable(mode_ff) && $stable(time_ff))
      else $error("state changed while response stalled");
`endif

endmodule
`default_nettype wire
